### rtl/sscs_pkg.sv
// Package with the count format, digit position codes and segment table for the display scanner.
`default_nettype none

package sscs_pkg;

    // Signed count kept as sign and BCD magnitude (0..1999).
    typedef struct packed {
        logic       neg;
        logic       thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } count_t;

    // Digit position codes of a result.
    typedef logic [1:0] pos_t;
    localparam pos_t POS_UNITS     = 2'd0;
    localparam pos_t POS_TENS      = 2'd1;
    localparam pos_t POS_HUNDREDS  = 2'd2;
    localparam pos_t POS_THOUSANDS = 2'd3;

    localparam logic [3:0] DIGIT_ZERO = 4'd0;
    localparam logic [3:0] DIGIT_ONE  = 4'd1;
    localparam logic [3:0] DIGIT_NINE = 4'd9;

    // Lit-segment codes for the thousands position (bit0 = a .. bit6 = g).
    localparam logic [6:0] SEG_ONE  = 7'h06;
    localparam logic [6:0] SEG_SIGN = 7'h40;

    localparam logic [7:0] FRAMES_PER_STEP_RESET = 8'd10;

    // Count after reset: +90.
    localparam count_t COUNT_RESET = '{neg: 1'b0, thou: 1'b0, hund: 4'd0,
                                       tens: 4'd9, units: 4'd0};
    // Top and bottom of the count range: +1999 and -1999.
    localparam count_t COUNT_TOP = '{neg: 1'b0, thou: 1'b1, hund: 4'd9,
                                     tens: 4'd9, units: 4'd9};
    localparam count_t COUNT_BOTTOM = '{neg: 1'b1, thou: 1'b1, hund: 4'd9,
                                        tens: 4'd9, units: 4'd9};
    // Minus one, reached when decrementing from zero.
    localparam count_t COUNT_MINUS_ONE = '{neg: 1'b1, thou: 1'b0, hund: 4'd0,
                                           tens: 4'd0, units: 4'd1};

    // Lit segments of a decimal digit.
    function automatic logic [6:0] seg_lit(input logic [3:0] digit);
        logic [6:0] lit;
        case (digit)
            4'd0:    lit = 7'h3f;
            4'd1:    lit = 7'h06;
            4'd2:    lit = 7'h5b;
            4'd3:    lit = 7'h4f;
            4'd4:    lit = 7'h66;
            4'd5:    lit = 7'h6d;
            4'd6:    lit = 7'h7d;
            4'd7:    lit = 7'h07;
            4'd8:    lit = 7'h7f;
            4'd9:    lit = 7'h6f;
            default: lit = 7'h00;
        endcase
        return lit;
    endfunction

    // Count minus one, wrapping from below -1999 to +1999.
    function automatic count_t count_dec(input count_t c);
        count_t r;
        logic   mag_zero;
        r = c;
        mag_zero = !c.thou && (c.hund == DIGIT_ZERO) && (c.tens == DIGIT_ZERO)
                   && (c.units == DIGIT_ZERO);
        if (c.neg) begin
            // Negative: the magnitude grows by one.
            if (c == COUNT_BOTTOM) begin
                r = COUNT_TOP;
            end else if (c.units != DIGIT_NINE) begin
                r.units = c.units + DIGIT_ONE;
            end else begin
                r.units = DIGIT_ZERO;
                if (c.tens != DIGIT_NINE) begin
                    r.tens = c.tens + DIGIT_ONE;
                end else begin
                    r.tens = DIGIT_ZERO;
                    if (c.hund != DIGIT_NINE) begin
                        r.hund = c.hund + DIGIT_ONE;
                    end else begin
                        r.hund = DIGIT_ZERO;
                        r.thou = 1'b1;
                    end
                end
            end
        end else if (mag_zero) begin
            r = COUNT_MINUS_ONE;
        end else begin
            // Positive: the magnitude shrinks by one with a borrow chain.
            if (c.units != DIGIT_ZERO) begin
                r.units = c.units - DIGIT_ONE;
            end else begin
                r.units = DIGIT_NINE;
                if (c.tens != DIGIT_ZERO) begin
                    r.tens = c.tens - DIGIT_ONE;
                end else begin
                    r.tens = DIGIT_NINE;
                    if (c.hund != DIGIT_ZERO) begin
                        r.hund = c.hund - DIGIT_ONE;
                    end else begin
                        r.hund = DIGIT_NINE;
                        r.thou = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/signed_counter_seven_segment_scan.sv
// An accepted frame tick is held as a pending frame until its four digits are loaded.
// Throughput: four results per frame tick, one per cycle while the output is not stalled,
// set by the single frame register that steps through the four digit positions; a new
// tick is taken as a frame's last digit loads; an idle tick (frame_tick = 0) gives none.
// Reset (aresetn low, synchronous): count +90, frame counter 0, frames_per_step 10,
// no frame pending and no result valid.
`default_nettype none

module signed_counter_seven_segment_scan (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_frames_per_step,
    // Frame tick channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_frame_tick,
    // Digit result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_digit_position,
    output logic [7:0]      m_segment_pattern,
    output logic            m_digit_on,
    output logic            m_last_digit
);

    sscs_pkg::count_t count_reg, count_next;
    sscs_pkg::count_t frame_count_reg;
    logic [7:0]       frame_counter_reg, frame_counter_next;
    logic [7:0]       fps_reg;
    logic             frame_valid_reg;
    sscs_pkg::pos_t   pos_reg;
    logic             m_valid_reg;
    logic [1:0]       m_pos_reg;
    logic [7:0]       m_pattern_reg;
    logic             m_on_reg;
    logic             m_last_reg;

    logic             out_load;
    logic             frame_done;
    logic             tick_accept;
    logic [7:0]       frame_inc;
    logic             step;
    logic [6:0]       res_lit;
    logic             res_on;

    // Handshakes: a result is loaded whenever a frame is pending and the output register is free or drained.
    assign cfg_ready   = 1'b1;
    assign out_load    = frame_valid_reg && (!m_valid_reg || m_ready);
    assign frame_done  = out_load && (pos_reg == sscs_pkg::POS_THOUSANDS);
    assign s_ready     = !frame_valid_reg || frame_done;
    assign tick_accept = s_valid && s_ready && s_frame_tick;

    // Frame counting and the count step that follows a completed frame.
    always_comb begin
        frame_inc = frame_counter_reg + 8'd1;
        if (fps_reg == 8'd0) begin
            step = (frame_inc == 8'd0);
        end else begin
            step = (frame_inc >= fps_reg);
        end
        count_next         = count_reg;
        frame_counter_next = frame_counter_reg;
        if (tick_accept) begin
            if (step) begin
                frame_counter_next = 8'd0;
                count_next         = sscs_pkg::count_dec(count_reg);
            end else begin
                frame_counter_next = frame_inc;
            end
        end
    end

    // Segments and enable of the digit at the current position.
    always_comb begin
        case (pos_reg)
            sscs_pkg::POS_UNITS: begin
                res_lit = sscs_pkg::seg_lit(frame_count_reg.units);
                res_on  = 1'b1;
            end
            sscs_pkg::POS_TENS: begin
                res_lit = sscs_pkg::seg_lit(frame_count_reg.tens);
                res_on  = (frame_count_reg.tens != sscs_pkg::DIGIT_ZERO)
                          || (frame_count_reg.hund != sscs_pkg::DIGIT_ZERO)
                          || frame_count_reg.thou;
            end
            sscs_pkg::POS_HUNDREDS: begin
                res_lit = sscs_pkg::seg_lit(frame_count_reg.hund);
                res_on  = (frame_count_reg.hund != sscs_pkg::DIGIT_ZERO)
                          || frame_count_reg.thou;
            end
            default: begin
                // Thousands: a '1' above 999 in magnitude, a minus sign when negative.
                res_lit = (frame_count_reg.thou ? sscs_pkg::SEG_ONE : 7'h00)
                          | (frame_count_reg.neg ? sscs_pkg::SEG_SIGN : 7'h00);
                res_on  = frame_count_reg.thou || frame_count_reg.neg;
            end
        endcase
    end

    // Control state: count, frame counter, configuration, digit position and valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg         <= sscs_pkg::COUNT_RESET;
            frame_counter_reg <= 8'd0;
            fps_reg           <= sscs_pkg::FRAMES_PER_STEP_RESET;
            frame_valid_reg   <= 1'b0;
            pos_reg           <= sscs_pkg::POS_UNITS;
            m_valid_reg       <= 1'b0;
        end else begin
            count_reg         <= count_next;
            frame_counter_reg <= frame_counter_next;
            if (cfg_valid && cfg_ready) begin
                fps_reg <= cfg_frames_per_step;
            end
            if (tick_accept) begin
                frame_valid_reg <= 1'b1;
                pos_reg         <= sscs_pkg::POS_UNITS;
            end else if (frame_done) begin
                frame_valid_reg <= 1'b0;
            end else if (out_load) begin
                pos_reg <= pos_reg + 2'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the frame snapshot and the result.
    always_ff @(posedge aclk) begin
        if (tick_accept) begin
            frame_count_reg <= count_reg;
        end
        if (out_load) begin
            m_pos_reg     <= pos_reg;
            m_pattern_reg <= {1'b1, ~res_lit};
            m_on_reg      <= res_on;
            m_last_reg    <= (pos_reg == sscs_pkg::POS_THOUSANDS);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_digit_position  = m_pos_reg;
    assign m_segment_pattern = m_pattern_reg;
    assign m_digit_on        = m_on_reg;
    assign m_last_digit      = m_last_reg;

`ifndef SYNTHESIS
    // The frame end flag marks the thousands position only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_last_digit != (m_digit_position == sscs_pkg::POS_THOUSANDS))
        |-> 1'b0)
        else $error("last_digit does not match the thousands position");

    // A new frame is taken over a pending one only as its last digit leaves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && frame_valid_reg |-> pos_reg == sscs_pkg::POS_THOUSANDS && out_load)
        else $error("frame tick accepted while a frame is still being scanned");

    // Every stored digit stays a decimal digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg.units <= sscs_pkg::DIGIT_NINE && count_reg.tens <= sscs_pkg::DIGIT_NINE
        && count_reg.hund <= sscs_pkg::DIGIT_NINE)
        else $error("count holds a non-decimal digit");

    // There is no negative zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg.neg |-> count_reg.thou || count_reg.hund != sscs_pkg::DIGIT_ZERO
        || count_reg.tens != sscs_pkg::DIGIT_ZERO || count_reg.units != sscs_pkg::DIGIT_ZERO)
        else $error("count holds a negative zero");
`endif

endmodule

`default_nettype wire
